/* rtl/core/raster_shape_draw_engine_assert.svh */
// Assertion macros for the raster shape draw engine.
// Depends on a clock named clock and a reset named reset in the using module.
`ifndef RASTER_SHAPE_DRAW_ENGINE_ASSERT_SVH
`define RASTER_SHAPE_DRAW_ENGINE_ASSERT_SVH
// Same-cycle implication.
`define RSDE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rsde assertion failed");
// Next-cycle implication.
`define RSDE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rsde assertion failed");
`endif

/* rtl/core/rsde_pkg.sv */
// Package for the raster shape draw engine: canvas sizes, codes, command word type.
// No dependencies.
`timescale 1ns / 1ps
package rsde_pkg;
   localparam int CANVAS_ROWS = 32;
   localparam int CANVAS_COLS = 64;
   localparam int ROW_W = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
   localparam int COL_W = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
   localparam int MEM_DEPTH = 1 << (ROW_W + COL_W);
   localparam int BOX_W = 9;
   localparam int DIST_W = 2 * BOX_W + 1;
   localparam logic [BOX_W-1:0] ROWS_B = BOX_W'(CANVAS_ROWS);
   localparam logic [BOX_W-1:0] COLS_B = BOX_W'(CANVAS_COLS);

   localparam logic [2:0] MODE_LINE = 3'd0;
   localparam logic [2:0] MODE_RECT = 3'd1;
   localparam logic [2:0] MODE_TRI = 3'd2;
   localparam logic [2:0] MODE_CIRCLE = 3'd3;
   localparam logic [2:0] MODE_ERASE = 3'd4;
   localparam logic [2:0] MODE_CLEAR = 3'd5;
   localparam logic [2:0] MODE_READ = 3'd6;
   localparam logic [2:0] MODE_UNUSED = 3'd7;

   localparam logic [1:0] CODE_BLANK = 2'd0;
   localparam logic [1:0] CODE_DASH = 2'd1;
   localparam logic [1:0] CODE_STAR = 2'd2;

   typedef enum logic [1:0] {OP_NOP, OP_SCAN, OP_READ} op_type;
   typedef enum logic [1:0] {PRED_ALL, PRED_RECT, PRED_TRI, PRED_RING} pred_type;
   typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_SCAN, ST_READ} state_type;

   typedef struct packed {
      op_type op;
      pred_type pred;
      logic [1:0] code;
      logic [BOX_W-1:0] row_start;
      logic [BOX_W-1:0] row_end;
      logic [BOX_W-1:0] col_start;
      logic [BOX_W-1:0] col_end;
      logic [BOX_W-1:0] org_row;
      logic [BOX_W-1:0] org_col;
      logic [BOX_W-1:0] a_m1;
      logic [BOX_W-1:0] b_m1;
      logic [DIST_W-1:0] lo;
      logic [DIST_W-1:0] hi;
   } cmd_type;

   function automatic logic [BOX_W-1:0] min_box(input logic [BOX_W-1:0] x,
                                                input logic [BOX_W-1:0] y);
      min_box = (x < y) ? x : y;
   endfunction

   // Whole-canvas blank sweep, used after reset.
   function automatic cmd_type clear_cmd();
      cmd_type c;
      c = '0;
      c.op = OP_SCAN;
      c.pred = PRED_ALL;
      c.code = CODE_BLANK;
      c.row_end = ROWS_B;
      c.col_end = COLS_B;
      clear_cmd = c;
   endfunction
endpackage

/* rtl/core/rsde_if.sv */
// Valid/ready channel interfaces for command and result words.
// Depends on nothing.
`timescale 1ns / 1ps
interface rsde_req_if;
   logic valid;
   logic ready;
   logic [2:0] mode;
   logic [4:0] row;
   logic [5:0] col;
   logic [6:0] size_a;
   logic [6:0] size_b;
   modport source (output valid, mode, row, col, size_a, size_b, input ready);
   modport sink (input valid, mode, row, col, size_a, size_b, output ready);
endinterface

interface rsde_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] cell_code;
   modport source (output valid, cell_code, input ready);
   modport sink (input valid, cell_code, output ready);
endinterface

/* rtl/core/raster_shape_draw_engine.sv */
// Each draw word writes its shape by a scan over the cells of its clipped bounding box; circle
// and clear scan the whole canvas, and a read answers from the registered canvas word.
// Throughput is set by the single write port of the canvas memory: one cell per cycle.
// Reset (synchronous, active high) starts a blanking sweep of the canvas; command
// words are queued meanwhile and run once the sweep ends.
`timescale 1ns / 1ps
module raster_shape_draw_engine (
   input  logic clock,
   input  logic reset,
   rsde_req_if.sink req_chan,
   rsde_rsp_if.source rsp_chan
);
   // front to queue
   logic push, push_ready;
   rsde_pkg::cmd_type push_cmd;
   // queue to back end
   logic pop, pop_valid;
   rsde_pkg::cmd_type pop_cmd;

   // Classify and clip each word, hold it until the queue takes it.
   rsde_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan),
      .push(push), .push_cmd(push_cmd), .push_ready(push_ready)
   );

   // Decouple accept from execution so new words land while a scan runs.
   rsde_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_cmd(push_cmd), .push_ready(push_ready),
      .pop(pop), .pop_valid(pop_valid), .pop_cmd(pop_cmd)
   );

   // Walk cells, write the canvas, answer reads through the result register.
   rsde_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(pop_valid), .q_cmd(pop_cmd), .pop(pop), .rsp_chan(rsp_chan)
   );
endmodule

/* rtl/core/rsde_front.sv */
// Front end: accepts command words, clips shapes to the canvas, holds one classified word.
// Depends on rsde_pkg and rsde_if.
`timescale 1ns / 1ps
module rsde_front (
   input  logic clock,
   input  logic reset,
   rsde_req_if.sink req_chan,
   output logic push,
   output rsde_pkg::cmd_type push_cmd,
   input  logic push_ready
);
   logic hold_valid_ff, hold_valid_in;
   rsde_pkg::cmd_type hold_cmd_ff, cmd;
   logic accept;
   logic [rsde_pkg::BOX_W-1:0] r, c, a, b;
   logic [13:0] sq;

   assign req_chan.ready = !hold_valid_ff || push_ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign push = hold_valid_ff;
   assign push_cmd = hold_cmd_ff;

   always_comb begin
      r = rsde_pkg::BOX_W'(req_chan.row);
      c = rsde_pkg::BOX_W'(req_chan.col);
      a = rsde_pkg::BOX_W'(req_chan.size_a);
      b = rsde_pkg::BOX_W'(req_chan.size_b);
      sq = 14'(req_chan.size_a) * 14'(req_chan.size_a);
      cmd = '0;
      cmd.op = rsde_pkg::OP_SCAN;
      cmd.pred = rsde_pkg::PRED_ALL;
      cmd.code = rsde_pkg::CODE_STAR;
      cmd.org_row = r;
      cmd.org_col = c;
      cmd.row_start = r;
      cmd.col_start = c;
      cmd.a_m1 = a - 1'b1;
      cmd.b_m1 = b - 1'b1;
      cmd.lo = rsde_pkg::DIST_W'(sq) - rsde_pkg::DIST_W'(req_chan.size_a);
      cmd.hi = rsde_pkg::DIST_W'(sq) + rsde_pkg::DIST_W'(req_chan.size_a);
      cmd.row_end = rsde_pkg::min_box(r + a, rsde_pkg::ROWS_B);
      cmd.col_end = rsde_pkg::min_box(c + b, rsde_pkg::COLS_B);
      case (req_chan.mode)
         rsde_pkg::MODE_LINE: begin
            cmd.code = rsde_pkg::CODE_DASH;
            cmd.row_end = rsde_pkg::min_box(r + 1'b1, rsde_pkg::ROWS_B);
            cmd.col_end = rsde_pkg::min_box(c + a, rsde_pkg::COLS_B);
         end
         rsde_pkg::MODE_RECT: cmd.pred = rsde_pkg::PRED_RECT;
         rsde_pkg::MODE_TRI: begin
            cmd.pred = rsde_pkg::PRED_TRI;
            cmd.col_end = rsde_pkg::min_box(c + a, rsde_pkg::COLS_B);
         end
         rsde_pkg::MODE_CIRCLE: begin
            cmd.pred = rsde_pkg::PRED_RING;
            cmd.row_start = '0;
            cmd.col_start = '0;
            cmd.row_end = rsde_pkg::ROWS_B;
            cmd.col_end = rsde_pkg::COLS_B;
         end
         rsde_pkg::MODE_ERASE: cmd.code = rsde_pkg::CODE_BLANK;
         rsde_pkg::MODE_CLEAR: cmd = rsde_pkg::clear_cmd();
         rsde_pkg::MODE_READ: begin
            cmd.op = (r < rsde_pkg::ROWS_B && c < rsde_pkg::COLS_B) ?
                     rsde_pkg::OP_READ : rsde_pkg::OP_NOP;
         end
         default: cmd.op = rsde_pkg::OP_NOP;
      endcase
      // drop shapes that clip to nothing
      if (cmd.op == rsde_pkg::OP_SCAN &&
          (cmd.row_start >= cmd.row_end || cmd.col_start >= cmd.col_end)) begin
         cmd.op = rsde_pkg::OP_NOP;
      end
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      if (accept) begin
         hold_cmd_ff <= cmd;
      end
   end
endmodule

/* rtl/core/rsde_queue.sv */
// Two-entry command queue between front and back end.
// Depends on rsde_pkg.
`timescale 1ns / 1ps
module rsde_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  rsde_pkg::cmd_type push_cmd,
   output logic push_ready,
   input  logic pop,
   output logic pop_valid,
   output rsde_pkg::cmd_type pop_cmd
);
   rsde_pkg::cmd_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule

/* rtl/core/rsde_back.sv */
// Back end: canvas memory, cell scanner that writes shapes, cell read and result register.
// Depends on rsde_pkg, rsde_if and raster_shape_draw_engine_assert.svh.
`timescale 1ns / 1ps
`include "raster_shape_draw_engine_assert.svh"
module rsde_back (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  rsde_pkg::cmd_type q_cmd,
   output logic pop,
   rsde_rsp_if.source rsp_chan
);
   logic [1:0] canvas_mem [rsde_pkg::MEM_DEPTH];
   rsde_pkg::state_type state_ff, state_in;
   rsde_pkg::cmd_type cmd_ff, cmd_in;
   logic [rsde_pkg::BOX_W-1:0] cur_row_ff, cur_row_in, cur_col_ff, cur_col_in;
   logic [1:0] rd_data_ff, rsp_code_ff, rsp_code_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rsde_pkg::BOX_W-1:0] di, dj, dx, dy;
   logic [rsde_pkg::DIST_W-1:0] dist_sq;
   logic hit, last, wr_en, scanning, set_zero, set_read;
   logic [rsde_pkg::ROW_W+rsde_pkg::COL_W-1:0] wr_addr, rd_addr;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.cell_code = rsp_code_ff;

   always_comb begin
      di = cur_row_ff - cmd_ff.org_row;
      dj = cur_col_ff - cmd_ff.org_col;
      dx = (cur_row_ff >= cmd_ff.org_row) ? di : cmd_ff.org_row - cur_row_ff;
      dy = (cur_col_ff >= cmd_ff.org_col) ? dj : cmd_ff.org_col - cur_col_ff;
      dist_sq = rsde_pkg::DIST_W'(dx) * rsde_pkg::DIST_W'(dx) +
                rsde_pkg::DIST_W'(dy) * rsde_pkg::DIST_W'(dy);
      case (cmd_ff.pred)
         rsde_pkg::PRED_ALL: hit = 1'b1;
         rsde_pkg::PRED_RECT: hit = (di == '0) || (di == cmd_ff.a_m1) ||
                                    (dj == '0) || (dj == cmd_ff.b_m1);
         rsde_pkg::PRED_TRI: hit = (dj == '0) || (dj == di) || (di == cmd_ff.a_m1);
         rsde_pkg::PRED_RING: hit = (dist_sq >= cmd_ff.lo) && (dist_sq <= cmd_ff.hi);
         default: hit = 1'b0;
      endcase
      last = (cur_row_ff == cmd_ff.row_end - 1'b1) &&
             (cur_col_ff == cmd_ff.col_end - 1'b1);
      wr_addr = {cur_row_ff[rsde_pkg::ROW_W-1:0], cur_col_ff[rsde_pkg::COL_W-1:0]};
      rd_addr = {q_cmd.org_row[rsde_pkg::ROW_W-1:0], q_cmd.org_col[rsde_pkg::COL_W-1:0]};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsde_pkg::ST_INIT: if (last) state_in = rsde_pkg::ST_IDLE;
         rsde_pkg::ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               case (q_cmd.op)
                  rsde_pkg::OP_SCAN: state_in = rsde_pkg::ST_SCAN;
                  rsde_pkg::OP_READ: state_in = rsde_pkg::ST_READ;
                  default: state_in = rsde_pkg::ST_IDLE;
               endcase
            end
         end
         rsde_pkg::ST_SCAN: if (last) state_in = rsde_pkg::ST_IDLE;
         rsde_pkg::ST_READ: state_in = rsde_pkg::ST_IDLE;
         default: state_in = rsde_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop = 1'b0;
      scanning = 1'b0;
      set_zero = 1'b0;
      set_read = 1'b0;
      case (state_ff)
         rsde_pkg::ST_INIT: scanning = 1'b1;
         rsde_pkg::ST_IDLE: begin
            pop = q_valid && !rsp_valid_ff;
            set_zero = pop && (q_cmd.op == rsde_pkg::OP_NOP);
         end
         rsde_pkg::ST_SCAN: begin
            scanning = 1'b1;
            set_zero = last;
         end
         rsde_pkg::ST_READ: set_read = 1'b1;
         default: pop = 1'b0;
      endcase
      wr_en = scanning && hit;
   end

   always_comb begin
      cmd_in = cmd_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      if (pop) begin
         cmd_in = q_cmd;
         cur_row_in = q_cmd.row_start;
         cur_col_in = q_cmd.col_start;
      end else if (scanning) begin
         if (cur_col_ff == cmd_ff.col_end - 1'b1) begin
            cur_col_in = cmd_ff.col_start;
            cur_row_in = cur_row_ff + 1'b1;
         end else begin
            cur_col_in = cur_col_ff + 1'b1;
         end
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in = rsp_code_ff;
      if (set_zero || set_read) begin
         rsp_valid_in = 1'b1;
         rsp_code_in = set_read ? rd_data_ff : rsde_pkg::CODE_BLANK;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsde_pkg::ST_INIT;
         cmd_ff <= rsde_pkg::clear_cmd();
         cur_row_ff <= '0;
         cur_col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmd_ff <= cmd_in;
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_code_ff <= rsp_code_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         canvas_mem[wr_addr] <= cmd_ff.code;
      end
      rd_data_ff <= canvas_mem[rd_addr];
   end

   `RSDE_ASSERT_NOW(a_wr_only_scan, wr_en,
      state_ff == rsde_pkg::ST_SCAN || state_ff == rsde_pkg::ST_INIT)
   `RSDE_ASSERT_NOW(a_pop_slot_free, pop, !rsp_valid_ff)
   `RSDE_ASSERT_NEXT(a_read_responds, state_ff == rsde_pkg::ST_READ, rsp_valid_ff)
   `RSDE_ASSERT_NOW(a_wr_in_canvas, wr_en,
      cur_row_ff < rsde_pkg::ROWS_B && cur_col_ff < rsde_pkg::COLS_B)
endmodule
